>>> src/sbq_pkg.sv
package sbq_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 32;
	localparam int COEF_FRAC   = COEF_BITS - 4;
	localparam int GAIN_BITS   = 24;
	localparam int GAIN_FRAC   = 18;
	localparam int SUR_FRAC    = 23;
	localparam int CIDX_BITS   = 6;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;
	localparam int PROD_BITS   = COEF_BITS + 1 + SAMPLE_BITS;
	localparam int ACC_BITS    = PROD_BITS + 3;
	localparam int SAT_BITS    = 40;

	localparam logic [CFG_IDX_BITS-1:0] CFG_EQ_ENABLE       = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PRE_GAIN        = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SURROUND_ENABLE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SURROUND_GAIN   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_POST_GAIN       = 3'd4;

	localparam logic CMD_PAIR       = 1'b0;
	localparam logic CMD_COEF_WRITE = 1'b1;

	localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 24'd262144;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0] coef_t;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_BQ,
		OP_PRE,
		OP_SUR,
		OP_POST
	} dp_op_t;

	// command from the sequencer to the datapath
	typedef struct packed {
		dp_op_t     op;
		logic [2:0] step;
		logic       ch;
		logic       out_load;
	} dp_cmd_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic eq_en;
		logic sur_en;
	} dp_stat_t;

	typedef struct packed {
		sample_t val;
		logic    clip;
	} sat_t;

	function automatic sat_t sat_sample(input logic signed [SAT_BITS-1:0] v);
		sat_t r;
		logic signed [SAT_BITS-1:0] hi;
		logic signed [SAT_BITS-1:0] lo;
		hi = SAT_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
		lo = -hi - SAT_BITS'(1);
		if (v > hi) begin
			r.val  = hi[SAMPLE_BITS-1:0];
			r.clip = 1'b1;
		end else if (v < lo) begin
			r.val  = lo[SAMPLE_BITS-1:0];
			r.clip = 1'b1;
		end else begin
			r.val  = v[SAMPLE_BITS-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> src/sbq_in_if.sv
interface sbq_in_if import sbq_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    cmd;
	sample_t left_sample;
	sample_t right_sample;
	logic [CIDX_BITS-1:0] coef_index;
	coef_t   coef_value;

	modport source (output valid, cmd, left_sample, right_sample, coef_index, coef_value,
		input ready);
	modport sink (input valid, cmd, left_sample, right_sample, coef_index, coef_value,
		output ready);
endinterface

>>> src/sbq_out_if.sv
interface sbq_out_if import sbq_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t left_out;
	sample_t right_out;
	logic    clipped;

	modport source (output valid, left_out, right_out, clipped, input ready);
	modport sink (input valid, left_out, right_out, clipped, output ready);
endinterface

>>> src/sbq_ctrl.sv
module sbq_ctrl import sbq_pkg::*; #(
	parameter int BANDS = 10
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_cmd,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic [((BANDS > 1) ? $clog2(BANDS) : 1)-1:0] band
);

	localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_BQ   = 6'b000010,
		S_PRE  = 6'b000100,
		S_SUR  = 6'b001000,
		S_POST = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [2:0] step_q, step_d;
	logic [BW-1:0] band_q, band_d;
	logic ch_q, ch_d;
	logic out_valid_q, out_valid_d;
	logic out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign band      = band_q;

	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		band_d      = band_q;
		ch_d        = ch_q;
		out_load    = 1'b0;
		out_valid_d = out_valid_q & ~out_ready;
		case (state_q)
			S_IDLE: begin
				step_d = 3'd0;
				band_d = '0;
				ch_d   = 1'b0;
				if (in_valid && in_cmd == CMD_PAIR) begin
					state_d = stat.eq_en ? S_BQ : S_DONE;
				end
			end
			S_BQ: begin
				step_d = step_q + 3'd1;
				if (step_q == 3'd7) begin
					ch_d = ~ch_q;
					if (ch_q) begin
						if (32'(band_q) == BANDS - 1) begin
							state_d = S_PRE;
							band_d  = '0;
						end else begin
							band_d = band_q + BW'(1);
						end
					end
				end
			end
			S_PRE: begin
				step_d = step_q + 3'd1;
				if (step_q == 3'd2) begin
					step_d  = 3'd0;
					state_d = stat.sur_en ? S_SUR : S_POST;
				end
			end
			S_SUR: begin
				step_d = step_q + 3'd1;
				if (step_q == 3'd2) begin
					step_d  = 3'd0;
					state_d = S_POST;
				end
			end
			S_POST: begin
				step_d = step_q + 3'd1;
				if (step_q == 3'd2) begin
					step_d  = 3'd0;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.step     = step_q;
		cmd.ch       = ch_q;
		cmd.out_load = out_load;
		case (state_q)
			S_BQ:    cmd.op = OP_BQ;
			S_PRE:   cmd.op = OP_PRE;
			S_SUR:   cmd.op = OP_SUR;
			S_POST:  cmd.op = OP_POST;
			default: cmd.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			band_q      <= '0;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			band_q      <= band_d;
			ch_q        <= ch_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

>>> src/sbq_datapath.sv
module sbq_datapath import sbq_pkg::*; #(
	parameter int BANDS       = 10,
	parameter int DELAY_DEPTH = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic     in_fire,
	input  logic     in_cmd,
	input  sample_t  in_left,
	input  sample_t  in_right,
	input  logic [CIDX_BITS-1:0] in_coef_index,
	input  coef_t    in_coef_value,
	input  dp_cmd_t  cmd,
	input  logic [((BANDS > 1) ? $clog2(BANDS) : 1)-1:0] band,
	output dp_stat_t stat,
	output sample_t  left_out,
	output sample_t  right_out,
	output logic     clipped
);

	localparam int SLOTS   = BANDS * 5;
	localparam int CA_BITS = $clog2(SLOTS);
	localparam int ROWS    = BANDS * 2;
	localparam int HA_BITS = $clog2(ROWS);
	localparam int PW      = $clog2(DELAY_DEPTH);
	localparam int ROW_BITS = 4 * SAMPLE_BITS;
	localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(64'sd1 <<< COEF_FRAC);
	localparam logic signed [ACC_BITS:0]  RND_BQ = (ACC_BITS+1)'(64'sd1 <<< (COEF_FRAC - 1));
	localparam logic signed [PROD_BITS:0] RND_G  = (PROD_BITS+1)'(64'sd1 <<< (GAIN_FRAC - 1));
	localparam logic signed [PROD_BITS:0] RND_S  = (PROD_BITS+1)'(64'sd1 <<< (SUR_FRAC - 1));

	// configuration
	logic eq_en_q, sur_en_q;
	logic [GAIN_BITS-1:0] pre_gain_q, sur_gain_q, post_gain_q;

	// memories and their valid marks
	coef_t coef_mem [SLOTS];
	logic [SLOTS-1:0] coef_valid_q;
	logic [ROW_BITS-1:0] hist_mem [ROWS];
	logic [ROWS-1:0] hist_valid_q;
	logic [2*SAMPLE_BITS-1:0] delay_mem [DELAY_DEPTH];
	logic [PW-1:0] ptr_q;
	logic wrapped_q;

	coef_t coef_raw_q;
	logic coef_ok_q, coef_b0_q;
	logic [ROW_BITS-1:0] hist_raw_q;
	logic hist_ok_q;
	logic [2*SAMPLE_BITS-1:0] del_raw_q;
	logic del_ok_q;

	// working registers
	sample_t l_q, r_q;
	logic clip_q;
	logic signed [PROD_BITS-1:0] prod_s1;
	logic mac_s1, first_s1, sub_s1;
	logic signed [ACC_BITS-1:0] acc_q;
	sample_t left_out_q, right_out_q;
	logic clipped_q;

	logic coef_we, coef_re, hist_re, hist_we, del_re, del_we;
	logic [CA_BITS-1:0] coef_waddr, coef_raddr;
	logic [HA_BITS-1:0] hist_addr;
	coef_t coef_cur;
	logic [ROW_BITS-1:0] hrow;
	sample_t h0, h1, h2, h3, cur, dl, dr;
	logic signed [COEF_BITS:0] a_op;
	sample_t b_op;
	logic signed [ACC_BITS:0] acc_rnd;
	logic signed [PROD_BITS:0] g_rnd, s_rnd;
	logic signed [SAT_BITS-1:0] g_val, s_val, y_val, s_sum;
	sat_t y_sat, g_sat, s_sat;

	assign stat.eq_en  = eq_en_q;
	assign stat.sur_en = sur_en_q;
	assign left_out    = left_out_q;
	assign right_out   = right_out_q;
	assign clipped     = clipped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_en_q     <= 1'b0;
			pre_gain_q  <= GAIN_UNITY;
			sur_en_q    <= 1'b0;
			sur_gain_q  <= '0;
			post_gain_q <= GAIN_UNITY;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EQ_ENABLE:       eq_en_q     <= cfg_wdata[0];
				CFG_PRE_GAIN:        pre_gain_q  <= cfg_wdata[GAIN_BITS-1:0];
				CFG_SURROUND_ENABLE: sur_en_q    <= cfg_wdata[0];
				CFG_SURROUND_GAIN:   sur_gain_q  <= cfg_wdata[GAIN_BITS-1:0];
				CFG_POST_GAIN:       post_gain_q <= cfg_wdata[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// address and enable decode
	assign coef_we    = in_fire && in_cmd == CMD_COEF_WRITE && 32'(in_coef_index) < SLOTS;
	assign coef_waddr = CA_BITS'(in_coef_index);
	assign coef_re    = cmd.op == OP_BQ && cmd.step <= 3'd4;
	assign coef_raddr = CA_BITS'(32'(band) * 5 + 32'(cmd.step));
	assign hist_addr  = HA_BITS'(32'(band) * 2 + 32'(cmd.ch));
	assign hist_re    = cmd.op == OP_BQ && cmd.step == 3'd0;
	assign hist_we    = cmd.op == OP_BQ && cmd.step == 3'd7;
	assign del_re     = cmd.op == OP_PRE && cmd.step == 3'd0;
	assign del_we     = cmd.op == OP_SUR && cmd.step == 3'd1;

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr] <= in_coef_value;
		end
		if (coef_re) begin
			coef_raw_q <= coef_mem[coef_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_addr] <= {h2, y_sat.val, h0, cur};
		end
		if (hist_re) begin
			hist_raw_q <= hist_mem[hist_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (del_we) begin
			delay_mem[ptr_q] <= {l_q, r_q};
		end
		if (del_re) begin
			del_raw_q <= delay_mem[ptr_q];
		end
	end

	// valid marks stand in for the reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_valid_q <= '0;
			hist_valid_q <= '0;
			coef_ok_q    <= 1'b0;
			coef_b0_q    <= 1'b0;
			hist_ok_q    <= 1'b0;
			del_ok_q     <= 1'b0;
			ptr_q        <= '0;
			wrapped_q    <= 1'b0;
		end else begin
			if (coef_we) begin
				coef_valid_q[coef_waddr] <= 1'b1;
			end
			if (coef_re) begin
				coef_ok_q <= coef_valid_q[coef_raddr];
				coef_b0_q <= cmd.step == 3'd0;
			end
			if (hist_we) begin
				hist_valid_q[hist_addr] <= 1'b1;
			end
			if (hist_re) begin
				hist_ok_q <= hist_valid_q[hist_addr];
			end
			if (del_re) begin
				del_ok_q <= wrapped_q;
			end
			if (cmd.op == OP_SUR && cmd.step == 3'd2) begin
				if (32'(ptr_q) == DELAY_DEPTH - 1) begin
					ptr_q     <= '0;
					wrapped_q <= 1'b1;
				end else begin
					ptr_q <= ptr_q + PW'(1);
				end
			end
		end
	end

	always_comb begin
		coef_cur = coef_ok_q ? coef_raw_q : (coef_b0_q ? COEF_ONE : '0);
		hrow     = hist_ok_q ? hist_raw_q : '0;
		h0       = hrow[SAMPLE_BITS-1:0];
		h1       = hrow[2*SAMPLE_BITS-1:SAMPLE_BITS];
		h2       = hrow[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
		h3       = hrow[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
		dl       = del_ok_q ? del_raw_q[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
		dr       = del_ok_q ? del_raw_q[SAMPLE_BITS-1:0] : '0;
		cur      = cmd.ch ? r_q : l_q;
	end

	// shared multiplier operand select
	always_comb begin
		a_op = {coef_cur[COEF_BITS-1], coef_cur};
		b_op = cur;
		case (cmd.op)
			OP_BQ: begin
				case (cmd.step)
					3'd2:    b_op = h0;
					3'd3:    b_op = h1;
					3'd4:    b_op = h2;
					3'd5:    b_op = h3;
					default: b_op = cur;
				endcase
			end
			OP_PRE: begin
				a_op = {{(COEF_BITS+1-GAIN_BITS){1'b0}}, pre_gain_q};
				b_op = (cmd.step == 3'd0) ? l_q : r_q;
			end
			OP_SUR: begin
				a_op = {{(COEF_BITS+1-GAIN_BITS){1'b0}}, sur_gain_q};
				b_op = (cmd.step == 3'd0) ? dr : dl;
			end
			OP_POST: begin
				a_op = {{(COEF_BITS+1-GAIN_BITS){1'b0}}, post_gain_q};
				b_op = (cmd.step == 3'd0) ? l_q : r_q;
			end
			default: ;
		endcase
	end

	// rounding and saturation of the registered product or sum
	always_comb begin
		acc_rnd = (ACC_BITS+1)'(acc_q) + RND_BQ;
		y_val   = SAT_BITS'(acc_rnd >>> COEF_FRAC);
		y_sat   = sat_sample(y_val);
		g_rnd   = (PROD_BITS+1)'(prod_s1) + RND_G;
		g_val   = SAT_BITS'(g_rnd >>> GAIN_FRAC);
		g_sat   = sat_sample(g_val);
		s_rnd   = (PROD_BITS+1)'(prod_s1) + RND_S;
		s_val   = SAT_BITS'(s_rnd >>> SUR_FRAC);
		s_sum   = s_val + SAT_BITS'((cmd.step == 3'd1) ? l_q : r_q);
		s_sat   = sat_sample(s_sum);
	end

	always_ff @(posedge clk) begin
		prod_s1  <= a_op * b_op;
		mac_s1   <= cmd.op == OP_BQ && cmd.step >= 3'd1 && cmd.step <= 3'd5;
		first_s1 <= cmd.step == 3'd1;
		sub_s1   <= cmd.step >= 3'd4;
		if (mac_s1) begin
			if (first_s1) begin
				acc_q <= ACC_BITS'(prod_s1);
			end else if (sub_s1) begin
				acc_q <= acc_q - ACC_BITS'(prod_s1);
			end else begin
				acc_q <= acc_q + ACC_BITS'(prod_s1);
			end
		end
		if (cmd.out_load) begin
			left_out_q  <= l_q;
			right_out_q <= r_q;
			clipped_q   <= clip_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_cmd == CMD_PAIR) begin
			l_q    <= in_left;
			r_q    <= in_right;
			clip_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_BQ: begin
					if (cmd.step == 3'd7) begin
						if (cmd.ch) begin
							r_q <= y_sat.val;
						end else begin
							l_q <= y_sat.val;
						end
						clip_q <= clip_q | y_sat.clip;
					end
				end
				OP_PRE, OP_POST: begin
					if (cmd.step == 3'd1) begin
						l_q    <= g_sat.val;
						clip_q <= clip_q | g_sat.clip;
					end else if (cmd.step == 3'd2) begin
						r_q    <= g_sat.val;
						clip_q <= clip_q | g_sat.clip;
					end
				end
				OP_SUR: begin
					if (cmd.step == 3'd1) begin
						l_q    <= s_sat.val;
						clip_q <= clip_q | s_sat.clip;
					end else if (cmd.step == 3'd2) begin
						r_q    <= s_sat.val;
						clip_q <= clip_q | s_sat.clip;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

>>> src/stereo_biquad_eq_surround_chain_core.sv
// an accepted pair runs through every band, left channel then right, then the pre-gain,
// surround (when on) and post-gain stages; with the equaliser off a pair skips all of these
// the single shared multiplier does eight steps per biquad; a new pair is accepted only
// once the previous one has been handed to the output register;
// a coefficient write is accepted while idle and leaves the sequencer idle
// reset: arst_n clears control, configuration, coefficient and history valid marks and
// the delay ring pointer at once; no clearing pass, the block is ready right after reset
module stereo_biquad_eq_surround_chain_core import sbq_pkg::*; #(
	parameter int BANDS       = 10,
	parameter int DELAY_DEPTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	sbq_in_if.sink    in_ch,
	sbq_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic [BW-1:0] band;
	logic in_fire;

	// an input transaction completes when valid meets ready
	assign in_fire = in_ch.valid & in_ch.ready;

	// sequencer: walks bands and channels, then the gain and surround stages,
	// and parks the finished pair in the output register
	sbq_ctrl #(
		.BANDS(BANDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_cmd    (in_ch.cmd),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd),
		.band      (band)
	);

	// datapath: coefficient, history and delay memories, one multiplier,
	// accumulator, rounding and saturation
	sbq_datapath #(
		.BANDS      (BANDS),
		.DELAY_DEPTH(DELAY_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_fire      (in_fire),
		.in_cmd       (in_ch.cmd),
		.in_left      (in_ch.left_sample),
		.in_right     (in_ch.right_sample),
		.in_coef_index(in_ch.coef_index),
		.in_coef_value(in_ch.coef_value),
		.cmd          (cmd),
		.band         (band),
		.stat         (stat),
		.left_out     (out_ch.left_out),
		.right_out    (out_ch.right_out),
		.clipped      (out_ch.clipped)
	);

endmodule
